// ----- src/sat_pkg.sv -----
// Shared types and codes for the section address translator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package sat_pkg;

    // Operation codes of a request beat
    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_MEM2FILE = 2'd1;
    localparam logic [1:0] OP_FILE2MEM = 2'd2;

    // Status codes of a response beat
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
    localparam logic [1:0] STAT_WRITTEN   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_HEADER_SIZE   = 2'd0;
    localparam logic [1:0] CFG_MEM_ALIGN     = 2'd1;
    localparam logic [1:0] CFG_FILE_ALIGN    = 2'd2;
    localparam logic [1:0] CFG_SECTION_COUNT = 2'd3;

    // Configuration reset values
    localparam logic [31:0] RST_HEADER_SIZE   = 32'd1024;
    localparam logic [31:0] RST_MEM_ALIGN     = 32'd4096;
    localparam logic [31:0] RST_FILE_ALIGN    = 32'd512;
    localparam logic [4:0]  RST_SECTION_COUNT = 5'd0;

    // One section descriptor, one word of the table memory
    typedef struct packed {
        logic [31:0] mem_start;
        logic [31:0] mem_length;
        logic [31:0] file_start;
        logic [31:0] file_length;
    } t_sect;

    // Table port controls
    typedef struct packed {
        logic we;
        logic re;
    } t_tbl_ctrl;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_state;

endpackage

`default_nettype wire

// ----- src/sat_req_if.sv -----
// Request channel: valid/ready handshake carrying one request beat.
// Standalone; used by the section address translator top level.
`timescale 1ns / 1ps
`default_nettype none

interface sat_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [3:0]  entry_index;
    logic [31:0] mem_offset;
    logic [31:0] mem_size;
    logic [31:0] file_offset;
    logic [31:0] file_size;
    logic [31:0] address;

    modport source (
        output valid, op, entry_index, mem_offset, mem_size, file_offset, file_size,
               address,
        input  ready
    );
    modport sink (
        input  valid, op, entry_index, mem_offset, mem_size, file_offset, file_size,
               address,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/sat_rsp_if.sv -----
// Response channel: valid/ready handshake carrying one response beat.
// Standalone; used by the section address translator top level.
`timescale 1ns / 1ps
`default_nettype none

interface sat_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] translated_address;
    logic [1:0]  status;

    modport source (
        output valid, translated_address, status,
        input  ready
    );
    modport sink (
        input  valid, translated_address, status,
        output ready
    );
endinterface

`default_nettype wire

// ----- src/section_address_translator.sv -----
// Section address translator top level: config registers, scan sequencer, output stage.
// Depends on sat_pkg, sat_req_if, sat_rsp_if and sat_table.
`timescale 1ns / 1ps
`default_nettype none

// Translates an address between memory-image offset and file offset using a
// table of up to MAX_SECTIONS section descriptors held in one memory. A request
// beat either writes a descriptor (op 0) or translates an address (op 1 memory to
// file, op 2 file to memory). Addresses below header_size, or any address when the
// two alignments are equal, pass through unchanged; otherwise the lowest-numbered
// section among the first min(section_count, MAX_SECTIONS) that holds the address
// rebases it, and a miss returns zero with status "not found". One request is
// handled at a time. A write, a pass-through, an unused op or an empty search goes
// from accept straight to the finish state, which loads the response register once
// it is free; a searched translation first scans the table memory, which delivers
// one descriptor per cycle, and the scan stops at the first hit or the last entry.
// A new request is taken the cycle after the response register loads. The response
// register lets the next request be accepted while a response waits. Descriptors
// must be written before a search reaches them; there is no clearing pass after
// reset. The user must write configuration only while no request is in flight;
// the block itself does not enforce this.

module section_address_translator
    import sat_pkg::*;
#(
    parameter int MAX_SECTIONS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    sat_req_if.sink          i_req,
    sat_rsp_if.source        o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [31:0] i_cfg_data
);

    localparam int AW = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
    localparam int CW = $clog2(MAX_SECTIONS + 1);
    localparam int LW = (CW > 5) ? CW : 5;

    // Configuration registers
    logic [31:0] r_header_size;
    logic [31:0] r_mem_align;
    logic [31:0] r_file_align;
    logic [4:0]  r_section_count;

    // Sequencer and datapath registers
    t_state      r_state, n_state;
    logic [1:0]  r_op;
    logic [31:0] r_addr;
    logic [1:0]  r_status;
    logic [31:0] r_hit_lo;
    logic [31:0] r_hit_dst;
    logic [AW-1:0] r_scan_idx;

    // Output stage
    logic        r_out_valid;
    logic [31:0] r_out_addr;
    logic [1:0]  r_out_status;

    // Combinational controls
    logic        w_in_ready;
    logic        w_accept;
    logic        w_load_out;
    t_tbl_ctrl   w_tbl_ctrl;
    logic [AW-1:0] w_rd_addr;
    logic        w_is_xlate;
    logic        w_pass;
    logic        w_need_scan;
    logic        w_slot_ok;
    logic [LW-1:0] w_limit;
    logic [LW-1:0] w_next_idx;
    logic        w_last;
    logic        w_hit;
    logic [31:0] w_src_lo;
    logic [31:0] w_src_len;
    logic [31:0] w_dst_lo;
    logic [31:0] w_src_hi;
    t_sect       w_rdata;
    t_sect       w_wdata;

    // Configuration write port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_size   <= RST_HEADER_SIZE;
            r_mem_align     <= RST_MEM_ALIGN;
            r_file_align    <= RST_FILE_ALIGN;
            r_section_count <= RST_SECTION_COUNT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HEADER_SIZE:   r_header_size   <= i_cfg_data;
                CFG_MEM_ALIGN:     r_mem_align     <= i_cfg_data;
                CFG_FILE_ALIGN:    r_file_align    <= i_cfg_data;
                CFG_SECTION_COUNT: r_section_count <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    // Searched entry count, clamped to the table depth
    always_comb begin
        if (LW'(r_section_count) > LW'(MAX_SECTIONS)) begin
            w_limit = LW'(MAX_SECTIONS);
        end else begin
            w_limit = LW'(r_section_count);
        end
    end

    // Request decode at accept
    assign w_accept    = i_req.valid && w_in_ready;
    assign w_is_xlate  = i_req.op inside {OP_MEM2FILE, OP_FILE2MEM};
    assign w_pass      = (i_req.address < r_header_size) || (r_mem_align == r_file_align);
    assign w_need_scan = w_is_xlate && !w_pass && (w_limit != '0);
    assign w_slot_ok   = LW'(i_req.entry_index) < LW'(MAX_SECTIONS);

    assign w_wdata = '{
        mem_start:   i_req.mem_offset,
        mem_length:  i_req.mem_size,
        file_start:  i_req.file_offset,
        file_length: i_req.file_size
    };

    // Range check on the descriptor presented by the table
    always_comb begin
        if (r_op == OP_MEM2FILE) begin
            w_src_lo  = w_rdata.mem_start;
            w_src_len = w_rdata.mem_length;
            w_dst_lo  = w_rdata.file_start;
        end else begin
            w_src_lo  = w_rdata.file_start;
            w_src_len = w_rdata.file_length;
            w_dst_lo  = w_rdata.mem_start;
        end
    end

    assign w_src_hi   = w_src_lo + w_src_len;
    assign w_hit      = (r_addr >= w_src_lo) && (r_addr < w_src_hi);
    assign w_next_idx = LW'(r_scan_idx) + LW'(1);
    assign w_last     = (w_next_idx == w_limit);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = w_need_scan ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN: begin
                if (w_hit || w_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        w_in_ready    = 1'b0;
        w_load_out    = 1'b0;
        w_tbl_ctrl.we = 1'b0;
        w_tbl_ctrl.re = 1'b0;
        w_rd_addr     = '0;
        case (r_state)
            S_IDLE: begin
                w_in_ready    = i_rst_n;
                w_tbl_ctrl.we = w_accept && (i_req.op == OP_WRITE) && w_slot_ok;
                w_tbl_ctrl.re = w_accept && w_need_scan;
            end
            S_SCAN: begin
                w_tbl_ctrl.re = !w_hit && !w_last;
                w_rd_addr     = w_next_idx[AW-1:0];
            end
            S_FINISH: begin
                w_load_out = !r_out_valid || o_rsp.ready;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Descriptor table
    sat_table #(
        .DEPTH (MAX_SECTIONS),
        .AW    (AW)
    ) u_table (
        .i_clk   (i_clk),
        .i_ctrl  (w_tbl_ctrl),
        .i_waddr (AW'(i_req.entry_index)),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    // Request datapath. The result is r_addr - r_hit_lo + r_hit_dst; setting
    // lo to the address and dst to zero yields the zero result of a miss or write.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_req.op;
            r_addr     <= i_req.address;
            r_scan_idx <= '0;
            r_hit_lo   <= i_req.address;
            r_hit_dst  <= '0;
            case (i_req.op)
                OP_WRITE: begin
                    r_status <= STAT_WRITTEN;
                end
                OP_MEM2FILE, OP_FILE2MEM: begin
                    if (w_pass) begin
                        r_status <= STAT_OK;
                        r_hit_lo <= '0;
                    end else begin
                        r_status <= STAT_NOT_FOUND;
                    end
                end
                default: begin
                    r_status <= STAT_NOT_FOUND;
                end
            endcase
        end else if (r_state == S_SCAN) begin
            if (w_hit) begin
                r_status  <= STAT_OK;
                r_hit_lo  <= w_src_lo;
                r_hit_dst <= w_dst_lo;
            end else if (!w_last) begin
                r_scan_idx <= w_next_idx[AW-1:0];
            end
        end
    end

    // Response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_addr   <= r_addr - r_hit_lo + r_hit_dst;
            r_out_status <= r_status;
        end
    end

    assign i_req.ready              = w_in_ready;
    assign o_rsp.valid              = r_out_valid;
    assign o_rsp.translated_address = r_out_addr;
    assign o_rsp.status             = r_out_status;

endmodule

`default_nettype wire

// ----- src/sat_table.sv -----
// Section descriptor table: single-port-write, registered-read memory.
// Depends on sat_pkg for the descriptor and control types.
`timescale 1ns / 1ps
`default_nettype none

module sat_table
    import sat_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic      i_clk,
    input  wire t_tbl_ctrl i_ctrl,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_sect     i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output      t_sect     o_rdata
);

    t_sect r_mem [DEPTH];
    t_sect r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_ctrl.we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        if (i_ctrl.re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/sat_checker.sv -----
// Port-level checks for the section address translator, bound to its top level.
// Depends on sat_pkg for status codes.
`timescale 1ns / 1ps
`default_nettype none

module sat_checker
    import sat_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_req_valid,
    input wire logic        i_req_ready,
    input wire logic        i_rsp_valid,
    input wire logic        i_rsp_ready,
    input wire logic [31:0] i_rsp_addr,
    input wire logic [1:0]  i_rsp_status
);

    // A response beat stays offered until taken
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> i_rsp_valid)
        else $error("response beat dropped before it was taken");

    // A stalled response beat keeps its payload
    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> ($stable(i_rsp_addr) && $stable(i_rsp_status)))
        else $error("stalled response payload changed");

    // Only a successful translation carries a nonzero address
    a_zero_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != STAT_OK)) |-> (i_rsp_addr == '0))
        else $error("nonzero address on a write or miss response");

    // One request in flight: ready drops right after an accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request accepted while another is in flight");

endmodule

bind section_address_translator sat_checker u_sat_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_addr   (o_rsp.translated_address),
    .i_rsp_status (o_rsp.status)
);

`default_nettype wire
